// ===== design/mpdg_pkg.sv =====
// mpdg_pkg: shared constants, period lookup and structs for the motor pwm duty generator
// no dependencies; used by every module under design/

package mpdg_pkg;

	// field widths fixed by the interface
	localparam int unsigned RATE_W  = 2;
	localparam int unsigned MASK_W  = 3;
	localparam int unsigned CODE_W  = 8;
	localparam int unsigned WIDTH_W = 6;
	localparam int unsigned LINES_W = 3;
	localparam int unsigned PCT_W   = 7;

	// default channel count for the top level parameter
	localparam int unsigned CHANNEL_COUNT_DEF = 3;

	// reset values of the configuration registers
	localparam logic [RATE_W-1:0] RATE_RESET = 2'd3;
	localparam logic [MASK_W-1:0] MASK_RESET = 3'd0;

	// register indexes on the configuration port
	localparam logic CFG_RATE = 1'b0;
	localparam logic CFG_MASK = 1'b1;

	// periods rounded from the switching frequencies, worked out at elaboration
	localparam int unsigned US_PER_SECOND = 1000000;
	localparam int unsigned FREQ_RATE0    = 53600;
	localparam int unsigned FREQ_RATE1    = 31250;
	localparam int unsigned FREQ_RATE2    = 20830;
	localparam int unsigned FREQ_START    = 21000;
	localparam int unsigned PERIOD_R0 = (US_PER_SECOND + FREQ_RATE0 / 2) / FREQ_RATE0;
	localparam int unsigned PERIOD_R1 = (US_PER_SECOND + FREQ_RATE1 / 2) / FREQ_RATE1;
	localparam int unsigned PERIOD_R2 = (US_PER_SECOND + FREQ_RATE2 / 2) / FREQ_RATE2;
	localparam int unsigned PERIOD_RS = (US_PER_SECOND + FREQ_START / 2) / FREQ_START;

	// duty arithmetic constants
	localparam int unsigned PCT_SCALE = 100;
	localparam int unsigned PCT_ROUND = 254;
	localparam int unsigned PCT_MAX   = 100;
	localparam int unsigned WID_ROUND = 50;
	// reciprocal of 100 scaled by 2^RECIP_SHIFT
	localparam int unsigned RECIP_SHIFT = 19;
	localparam int unsigned RECIP_100   = 5243;

	// rate select codes
	typedef enum logic [RATE_W-1:0] {
		RATE_FAST  = 2'd0,
		RATE_MID   = 2'd1,
		RATE_SLOW  = 2'd2,
		RATE_START = 2'd3
	} rate_t;

	// one input request as held in the input register
	typedef struct packed {
		logic              cmd;
		logic [CODE_W-1:0] duty_code;
	} item_t;

	// one result request
	typedef struct packed {
		logic [LINES_W-1:0] pwm_lines;
		logic               cycle_start;
		logic [WIDTH_W-1:0] pulse_width_us;
	} result_t;

	// period in microseconds for a rate select code
	function automatic logic [WIDTH_W-1:0] period_of(input logic [RATE_W-1:0] rate);
		logic [WIDTH_W-1:0] p;
		case (rate_t'(rate))
			RATE_FAST:  p = WIDTH_W'(PERIOD_R0);
			RATE_MID:   p = WIDTH_W'(PERIOD_R1);
			RATE_SLOW:  p = WIDTH_W'(PERIOD_R2);
			RATE_START: p = WIDTH_W'(PERIOD_RS);
			default:    p = WIDTH_W'(PERIOD_RS);
		endcase
		return p;
	endfunction

endpackage

// ===== design/mpdg_duty_conv.sv =====
// mpdg_duty_conv: turns an 8-bit duty code into a rounded pulse width for a given period
// depends on mpdg_pkg

module mpdg_duty_conv (
	input  logic [mpdg_pkg::CODE_W-1:0]  duty_code,
	input  logic [mpdg_pkg::WIDTH_W-1:0] period,
	output logic [mpdg_pkg::WIDTH_W-1:0] width
);

	logic [14:0]                       pct_num;
	logic [14:0]                       pct_sum;
	logic [6:0]                        pct_raw;
	logic [mpdg_pkg::PCT_W-1:0]        pct;
	logic [12:0]                       wid_num;
	logic [24:0]                       wid_prod;

	// percent rounded up: divide by 255 as (x + 1 + x/256) / 256
	assign pct_num = 15'(duty_code) * 15'(mpdg_pkg::PCT_SCALE) + 15'(mpdg_pkg::PCT_ROUND);
	assign pct_sum = pct_num + 15'd1 + 15'(pct_num[14:8]);
	assign pct_raw = pct_sum[14:8];

	// clamp at full duty
	assign pct = (pct_raw > 7'(mpdg_pkg::PCT_MAX)) ? 7'(mpdg_pkg::PCT_MAX) : pct_raw;

	// rounded width: divide by 100 through a scaled reciprocal
	assign wid_num  = 13'(period) * 13'(pct) + 13'(mpdg_pkg::WID_ROUND);
	assign wid_prod = 25'(wid_num) * 25'(mpdg_pkg::RECIP_100);
	assign width    = wid_prod[mpdg_pkg::RECIP_SHIFT +: mpdg_pkg::WIDTH_W];

endmodule

// ===== design/mpdg_period_core.sv =====
// mpdg_period_core: configuration registers, period counter, shadow and active width
// depends on mpdg_pkg and mpdg_duty_conv

module mpdg_period_core #(
	parameter int unsigned CHANNEL_COUNT = mpdg_pkg::CHANNEL_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [mpdg_pkg::MASK_W-1:0] cfg_data,
	input  logic                        advance,
	input  mpdg_pkg::item_t             item_s1,
	output mpdg_pkg::result_t           result
);

	logic [mpdg_pkg::RATE_W-1:0]  rate_q;
	logic [mpdg_pkg::MASK_W-1:0]  mask_q;
	logic [mpdg_pkg::WIDTH_W-1:0] tick_q;
	logic [mpdg_pkg::WIDTH_W-1:0] active_q;
	logic [mpdg_pkg::WIDTH_W-1:0] pending_q;

	logic [mpdg_pkg::WIDTH_W-1:0]  period;
	logic [mpdg_pkg::WIDTH_W-1:0]  new_width;
	logic [mpdg_pkg::WIDTH_W-1:0]  count;
	logic [mpdg_pkg::WIDTH_W:0]    count_inc;
	logic                          start;
	logic [mpdg_pkg::WIDTH_W-1:0]  active_next;
	logic [mpdg_pkg::WIDTH_W-1:0]  tick_next;
	logic [mpdg_pkg::LINES_W-1:0]  enabled;

	assign period = mpdg_pkg::period_of(rate_q);

	mpdg_duty_conv u_conv (
		.duty_code (item_s1.duty_code),
		.period    (period),
		.width     (new_width)
	);

	// channels beyond the configured count never drive
	always_comb begin
		for (int i = 0; i < mpdg_pkg::LINES_W; i++) begin
			enabled[i] = mask_q[i] && (i < CHANNEL_COUNT);
		end
	end

	// count position; a stale count past a shortened period restarts it
	assign count       = (tick_q >= period) ? '0 : tick_q;
	assign start       = (count == '0);
	assign active_next = start ? pending_q : active_q;
	assign count_inc   = {1'b0, count} + 7'd1;
	assign tick_next   = (count_inc >= {1'b0, period}) ? '0 : count_inc[mpdg_pkg::WIDTH_W-1:0];

	// result of the request in the input register
	always_comb begin
		if (item_s1.cmd) begin
			result.pwm_lines      = '0;
			result.cycle_start    = 1'b0;
			result.pulse_width_us = active_q;
		end else begin
			result.pwm_lines      = (count < active_next) ? enabled : '0;
			result.cycle_start    = start;
			result.pulse_width_us = active_next;
		end
	end

	// state update on config writes and processed requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= mpdg_pkg::RATE_RESET;
			mask_q    <= mpdg_pkg::MASK_RESET;
			tick_q    <= '0;
			active_q  <= '0;
			pending_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mpdg_pkg::CFG_RATE: begin
						if (cfg_data[mpdg_pkg::RATE_W-1:0] != rate_q) begin
							rate_q    <= cfg_data[mpdg_pkg::RATE_W-1:0];
							pending_q <= '0;
						end
					end
					mpdg_pkg::CFG_MASK: mask_q <= cfg_data;
					default: ;
				endcase
			end else if (advance) begin
				if (item_s1.cmd) begin
					pending_q <= new_width;
				end else begin
					active_q <= active_next;
					tick_q   <= tick_next;
				end
			end
		end
	end

endmodule

// ===== design/motor_pwm_duty_generator.sv =====
// motor_pwm_duty_generator: top level with input register, output register and assertions
// depends on mpdg_pkg and mpdg_period_core

// Three-channel single-edge PWM driven by one request per microsecond tick. A request with
// cmd=0 advances the period counter and returns the channel levels for that tick; cmd=1
// converts duty_code to a pulse width that is loaded at the next period start. One request
// is accepted every clock cycle unless a result stalls on out_ready; each result goes from
// the input register, which holds the request, to the result register, which captures its
// result, and the result register lets the next request enter while a result still waits.
// rate_select (index 0) sets a 19, 32 or 48 us period and clears the pending width when it
// changes; channel_mask (index 1) enables channels. Write configuration only while no
// request is in flight.
module motor_pwm_duty_generator #(
	parameter int unsigned CHANNEL_COUNT = mpdg_pkg::CHANNEL_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [mpdg_pkg::MASK_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [mpdg_pkg::CODE_W-1:0]  duty_code,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mpdg_pkg::LINES_W-1:0] pwm_lines,
	output logic                         cycle_start,
	output logic [mpdg_pkg::WIDTH_W-1:0] pulse_width_us
);

	logic               valid_s1;
	mpdg_pkg::item_t    item_s1;
	logic               out_valid_q;
	mpdg_pkg::result_t  result;
	mpdg_pkg::result_t  result_q;
	logic               advance;

	// request moves from input register to result register
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd       <= cmd;
			item_s1.duty_code <= duty_code;
		end
	end

	mpdg_period_core #(
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.item_s1   (item_s1),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign pwm_lines      = result_q.pwm_lines;
	assign cycle_start    = result_q.cycle_start;
	assign pulse_width_us = result_q.pulse_width_us;

`ifndef SYNTHESIS
	// a zero pulse width never drives a line
	a_zero_width_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (pulse_width_us == '0)) |-> (pwm_lines == '0))
		else $error("pwm line high with zero pulse width");

	// width never exceeds the longest period
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pulse_width_us <= 6'(mpdg_pkg::PERIOD_RS)))
		else $error("pulse width beyond period");

	// a held request and a stalled result block new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && !out_ready) |-> !in_ready)
		else $error("request accepted while pipeline is full");

	// a taken result with a waiting request is replaced at the next edge
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_ready) |=> out_valid)
		else $error("result register not refilled");
`endif

endmodule

// ===== dv/tb_motor_pwm_duty_generator.sv =====
// tb_motor_pwm_duty_generator: self-checking testbench for the motor pwm duty generator
// depends on mpdg_pkg and motor_pwm_duty_generator; predicts every result in step with the block
`timescale 1ns / 1ps

module tb_motor_pwm_duty_generator;
	import mpdg_pkg::*;

	// one queued input request plus the idle time the sender spends after it
	typedef struct {
		logic              cmd;
		logic [CODE_W-1:0] code;
		int unsigned       gap;
	} drive_req_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [MASK_W-1:0]   cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                cmd;
	logic [CODE_W-1:0]   duty_code;
	logic                out_valid;
	logic                out_ready;
	logic [LINES_W-1:0]  pwm_lines;
	logic                cycle_start;
	logic [WIDTH_W-1:0]  pulse_width_us;

	// predicted block state
	rate_t               cur_rate;
	logic [MASK_W-1:0]   cur_mask;
	logic [WIDTH_W-1:0]  tick_pos;
	logic [WIDTH_W-1:0]  width_live;
	logic [WIDTH_W-1:0]  width_shadow;

	drive_req_t          pending_reqs[$];
	result_t             expected_pwm[$];
	drive_req_t          nxt;
	logic                in_fire;
	logic                out_fire;
	int unsigned         tx_wait;
	int unsigned         rx_wait;
	bit                  tx_busy;
	bit                  rx_busy;
	int unsigned         fault_count;

	motor_pwm_duty_generator u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.duty_code      (duty_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pwm_lines      (pwm_lines),
		.cycle_start    (cycle_start),
		.pulse_width_us (pulse_width_us)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// period in microseconds, rounded from the switching frequency
	function automatic int unsigned period_for_rate(input rate_t r);
		int unsigned f;
		case (r)
			RATE_FAST:  f = FREQ_RATE0;
			RATE_MID:   f = FREQ_RATE1;
			RATE_SLOW:  f = FREQ_RATE2;
			default:    f = FREQ_START;
		endcase
		return (US_PER_SECOND + f / 2) / f;
	endfunction

	// advance the predicted pwm state by one request and return its result
	function result_t pwm_step(input logic c, input logic [CODE_W-1:0] code);
		result_t     res;
		int unsigned period;
		int unsigned pct;
		int unsigned pos;
		period = period_for_rate(cur_rate);
		res = '0;
		if (c) begin
			// duty code: round up to a percent, then to a width in us
			pct = (int'(code) * 100 + 254) / 255;
			if (pct > 100)
				pct = 100;
			width_shadow = WIDTH_W'((period * pct + 50) / 100);
			res.pulse_width_us = width_live;
		end else begin
			// tick: a count past the period (after a shorter rate) restarts the period
			pos = tick_pos;
			if (pos >= period)
				pos = 0;
			if (pos == 0) begin
				width_live = width_shadow;
				res.cycle_start = 1'b1;
			end
			if (pos < width_live)
				res.pwm_lines = cur_mask;
			tick_pos = (pos + 1 >= period) ? '0 : WIDTH_W'(pos + 1);
			res.pulse_width_us = width_live;
		end
		return res;
	endfunction

	task automatic log_mismatch(input string what, input result_t want, input result_t got);
		fault_count++;
		if (fault_count <= 10)
			$display("%s: expected lines=%0d start=%0d width=%0d, got lines=%0d start=%0d width=%0d",
				what, want.pwm_lines, want.cycle_start, want.pulse_width_us,
				got.pwm_lines, got.cycle_start, got.pulse_width_us);
	endtask

	// request driver, fed from the pending queue
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (tx_wait != 0) begin
				tx_wait = tx_wait - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				nxt = pending_reqs.pop_front();
				cmd <= nxt.cmd;
				duty_code <= nxt.code;
				in_valid <= 1'b1;
				tx_wait = nxt.gap;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire)
				rx_wait = rx_busy ? $urandom_range(0, 7) : 0;
			if (rx_wait != 0) begin
				rx_wait = rx_wait - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		result_t got;
		result_t want;
		in_fire <= arst_n && in_valid && in_ready;
		out_fire <= arst_n && out_valid && out_ready;
		if (arst_n && in_valid && in_ready)
			expected_pwm.push_back(pwm_step(cmd, duty_code));
		if (arst_n && out_valid && out_ready) begin
			got.pwm_lines = pwm_lines;
			got.cycle_start = cycle_start;
			got.pulse_width_us = pulse_width_us;
			if (expected_pwm.size() == 0) begin
				log_mismatch("unexpected result", '0, got);
			end else begin
				want = expected_pwm.pop_front();
				if (got.pwm_lines !== want.pwm_lines || got.cycle_start !== want.cycle_start ||
						got.pulse_width_us !== want.pulse_width_us)
					log_mismatch("result mismatch", want, got);
			end
		end
	end

	task automatic queue_req(input logic c, input logic [CODE_W-1:0] code);
		drive_req_t r;
		r.cmd = c;
		r.code = code;
		r.gap = tx_busy ? $urandom_range(0, 7) : 0;
		pending_reqs.push_back(r);
	endtask

	// wait until the sender is empty and every result has come back
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || in_valid || expected_pwm.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write, only issued while the block is idle
	task automatic write_reg(input logic idx, input logic [MASK_W-1:0] data);
		rate_t r;
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_RATE) begin
			r = rate_t'(data[RATE_W-1:0]);
			if (r != cur_rate) begin
				cur_rate = r;
				width_shadow = '0;
			end
		end else begin
			cur_mask = data;
		end
	endtask

	function automatic logic [CODE_W-1:0] pick_code();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			3: return 8'd255;
			default: return CODE_W'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int unsigned n_items;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = 1'b0;
		duty_code = '0;
		out_ready = 1'b0;
		in_fire = 1'b0;
		out_fire = 1'b0;
		tx_wait = 0;
		rx_wait = 0;
		fault_count = 0;
		cur_rate = rate_t'(RATE_RESET);
		cur_mask = MASK_RESET;
		tick_pos = '0;
		width_live = '0;
		width_shadow = '0;
		tx_busy = 1'b1;
		rx_busy = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: width extremes, repeated duty code, ignored code on ticks
		write_reg(CFG_MASK, 3'd7);
		queue_req(1'b1, 8'd255);
		queue_req(1'b0, 8'd255);
		queue_req(1'b0, 8'd0);
		queue_req(1'b0, 8'd170);
		queue_req(1'b1, 8'd0);
		queue_req(1'b1, 8'd0);
		queue_req(1'b0, 8'd85);
		queue_req(1'b1, 8'd1);
		queue_req(1'b1, 8'd254);
		queue_req(1'b1, 8'd128);
		queue_req(1'b0, 8'd0);
		wait_idle();
		// rate changes zero the shadow width, including a change to a shorter period
		write_reg(CFG_RATE, RATE_SLOW);
		queue_req(1'b1, 8'd200);
		queue_req(1'b0, 8'd0);
		wait_idle();
		write_reg(CFG_RATE, RATE_FAST);
		write_reg(CFG_MASK, 3'd5);
		queue_req(1'b1, 8'd255);
		repeat (6) queue_req(1'b0, 8'd0);
		wait_idle();

		// random phases over every rate and over random mask settings
		for (int phase = 0; phase < 10; phase++) begin
			tx_busy = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
			rx_busy = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
			write_reg(CFG_RATE, (phase < 4) ? MASK_W'(phase) : MASK_W'($urandom_range(0, 7)));
			if (phase == 6)
				write_reg(CFG_RATE, MASK_W'(cur_rate));
			write_reg(CFG_MASK, (phase == 0) ? 3'd7 : (phase == 1) ? 3'd0 :
				MASK_W'($urandom_range(0, 7)));
			n_items = 75;
			for (int i = 0; i < n_items; i++) begin
				// sender holds off mid-phase until every result is back
				if (phase == 5 && i == n_items / 2)
					wait_idle();
				if ($urandom_range(0, 9) == 0)
					queue_req(1'b1, pick_code());
				else
					queue_req(1'b0, CODE_W'($urandom_range(0, 255)));
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (expected_pwm.size() != 0)
			fault_count++;
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
